@@ src/lpfd_pkg.sv @@
// Package for the length-prefixed frame deframer.
// Holds status codes, register indexes and register reset values.
// No dependencies.
package lpfd_pkg;

   // Widths of the byte stream, status code, tail, byte counter and register index
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned TAIL_W   = 4;
   localparam int unsigned CNT_W    = 9;
   localparam int unsigned CSR_AW   = 3;

   // Per-byte status reported on the result channel
   typedef enum logic [STATUS_W-1:0] {
      ST_START_OK  = 3'd0,
      ST_LEN_OK    = 3'd1,
      ST_BODY      = 3'd2,
      ST_BAD_START = 3'd3,
      ST_BAD_LEN   = 3'd4
   } status_type;

   // Configuration register indexes
   localparam logic [CSR_AW-1:0] REG_PRIMARY_START   = 3'd0;
   localparam logic [CSR_AW-1:0] REG_ALTERNATE_START = 3'd1;
   localparam logic [CSR_AW-1:0] REG_ALTERNATE_TAIL  = 3'd2;
   localparam logic [CSR_AW-1:0] REG_MIN_LENGTH      = 3'd3;
   localparam logic [CSR_AW-1:0] REG_MAX_LENGTH      = 3'd4;

   // Register values after reset
   localparam logic [BYTE_W-1:0] RST_PRIMARY_START   = 8'h68;
   localparam logic [BYTE_W-1:0] RST_ALTERNATE_START = 8'h16;
   localparam logic [TAIL_W-1:0] RST_ALTERNATE_TAIL  = 4'd4;
   localparam logic [BYTE_W-1:0] RST_MIN_LENGTH      = 8'd4;
   localparam logic [BYTE_W-1:0] RST_MAX_LENGTH      = 8'd253;

endpackage

@@ src/length_prefixed_frame_deframer_top.sv @@
// Top level of the length-prefixed frame deframer.
// Uses lpfd_pkg for status codes, register indexes and reset values.
//
// Deframer for length-prefixed telecontrol frames, one byte per transaction.
// Every byte accepted on req produces exactly one transaction on rsp, valid
// in the cycle after it is accepted: the byte itself in rsp_tdata, its
// status in rsp_tuser and rsp_tlast set on the byte that completes a valid
// frame. Throughput is one byte per cycle unless rsp stalls; the frame state
// update and the result register are the only stage, and req_tready stays
// high as long as the result register is empty or being drained in the same cycle.
// While hunting, a byte that matches neither start code is reported as a
// bad start; a length byte outside [min_length, max_length] is reported as a
// bad length and hunting resumes. Frames opened by the alternate start code
// carry alternate_tail_bytes extra bytes after the body. Write the
// configuration registers only while no transaction is in flight.
module length_prefixed_frame_deframer_top (
   input  logic                          clock,
   input  logic                          reset,
   // Input byte stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lpfd_pkg::BYTE_W-1:0]   req_tdata,   // [7:0] data_byte
   // Result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lpfd_pkg::BYTE_W-1:0]   rsp_tdata,   // [7:0] echo_byte
   output logic [lpfd_pkg::STATUS_W-1:0] rsp_tuser,   // [2:0] status
   output logic                          rsp_tlast,   // last_of_frame
   // Configuration write port
   input  logic                          csr_we,
   input  logic [lpfd_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [lpfd_pkg::BYTE_W-1:0]   csr_wdata
);

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   // Configuration registers
   logic [lpfd_pkg::BYTE_W-1:0] primary_start_ff;
   logic [lpfd_pkg::BYTE_W-1:0] alternate_start_ff;
   logic [lpfd_pkg::TAIL_W-1:0] alternate_tail_ff;
   logic [lpfd_pkg::BYTE_W-1:0] min_length_ff;
   logic [lpfd_pkg::BYTE_W-1:0] max_length_ff;

   // Frame state
   phase_type                   phase_ff,     phase_in;
   logic [lpfd_pkg::CNT_W-1:0]  remaining_ff, remaining_in;
   logic                        alternate_ff, alternate_in;

   // Result register
   logic                        rsp_valid_ff;
   logic [lpfd_pkg::BYTE_W-1:0] rsp_byte_ff;
   lpfd_pkg::status_type        rsp_status_ff, status_in;
   logic                        rsp_last_ff,   last_in;

   logic                        accept;
   logic [lpfd_pkg::CNT_W-1:0]  length_sum;
   logic [lpfd_pkg::CNT_W-1:0]  remaining_dec;
   logic                        is_primary;
   logic                        is_alternate;

   // Take a new byte when the result register is free or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign is_primary    = (req_tdata == primary_start_ff);
   assign is_alternate  = (req_tdata == alternate_start_ff);
   assign length_sum    = {1'b0, req_tdata}
                        + (alternate_ff ? {{(lpfd_pkg::CNT_W-lpfd_pkg::TAIL_W){1'b0}},
                                           alternate_tail_ff}
                                        : {lpfd_pkg::CNT_W{1'b0}});
   assign remaining_dec = remaining_ff - {{(lpfd_pkg::CNT_W-1){1'b0}}, 1'b1};

   // Next frame state and result for the byte on req_tdata
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      alternate_in = alternate_ff;
      status_in    = lpfd_pkg::ST_BAD_START;
      last_in      = 1'b0;
      unique case (phase_ff)
         PH_LEN: begin
            if (req_tdata < min_length_ff || req_tdata > max_length_ff) begin
               status_in    = lpfd_pkg::ST_BAD_LEN;
               phase_in     = PH_HUNT;
               remaining_in = '0;
            end else begin
               status_in    = lpfd_pkg::ST_LEN_OK;
               remaining_in = length_sum;
               if (length_sum == '0) begin
                  last_in  = 1'b1;
                  phase_in = PH_HUNT;
               end else begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            status_in    = lpfd_pkg::ST_BODY;
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               last_in  = 1'b1;
               phase_in = PH_HUNT;
            end
         end
         default: begin
            // Hunting; an unused phase code behaves the same way
            if (is_primary || is_alternate) begin
               status_in    = lpfd_pkg::ST_START_OK;
               alternate_in = is_alternate;
               remaining_in = '0;
               phase_in     = PH_LEN;
            end else begin
               status_in = lpfd_pkg::ST_BAD_START;
               phase_in  = PH_HUNT;
            end
         end
      endcase
   end

   // Configuration writes; out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         primary_start_ff   <= lpfd_pkg::RST_PRIMARY_START;
         alternate_start_ff <= lpfd_pkg::RST_ALTERNATE_START;
         alternate_tail_ff  <= lpfd_pkg::RST_ALTERNATE_TAIL;
         min_length_ff      <= lpfd_pkg::RST_MIN_LENGTH;
         max_length_ff      <= lpfd_pkg::RST_MAX_LENGTH;
      end else if (csr_we) begin
         unique case (csr_addr)
            lpfd_pkg::REG_PRIMARY_START:   primary_start_ff   <= csr_wdata;
            lpfd_pkg::REG_ALTERNATE_START: alternate_start_ff <= csr_wdata;
            lpfd_pkg::REG_ALTERNATE_TAIL:  alternate_tail_ff  <= csr_wdata[lpfd_pkg::TAIL_W-1:0];
            lpfd_pkg::REG_MIN_LENGTH:      min_length_ff      <= csr_wdata;
            lpfd_pkg::REG_MAX_LENGTH:      max_length_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance frame state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         remaining_ff <= '0;
         alternate_ff <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         alternate_ff <= alternate_in;
      end
   end

   // Result register valid: load on accept, clear when drained
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload; hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff   <= req_tdata;
         rsp_status_ff <= status_in;
         rsp_last_ff   <= last_in;
      end
   end

   // A body phase always has bytes still due
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> remaining_ff != '0)
      else $error("body phase with no bytes remaining");

   // Only a length or body byte may complete a frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |->
         (rsp_status_ff == lpfd_pkg::ST_LEN_OK || rsp_status_ff == lpfd_pkg::ST_BODY))
      else $error("frame end marked on a start or error byte");

   // A completed frame or error returns to hunting
   assert property (@(posedge clock) disable iff (reset)
      accept && (last_in || status_in == lpfd_pkg::ST_BAD_LEN) |=> phase_ff == PH_HUNT)
      else $error("frame state not back to hunting after frame end");

   // A good start byte always moves to the length phase
   assert property (@(posedge clock) disable iff (reset)
      accept && status_in == lpfd_pkg::ST_START_OK |=> phase_ff == PH_LEN)
      else $error("start byte did not open a length phase");

   // Every accepted byte leaves a result waiting
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted byte produced no result");

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for length_prefixed_frame_deframer_top.
// Drives byte transactions, predicts each result in place and compares it.
// Depends on lpfd_pkg and the RTL of the deframer only.
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int MAX_REPORTS    = 10;

   // Frame tracking state of the predictor
   typedef enum logic [1:0] {
      HUNTING,
      AWAIT_LENGTH,
      IN_BODY
   } deframe_phase_type;

   // Receiver stall behavior
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PATTERN
   } rx_mode_type;

   typedef struct packed {
      logic [lpfd_pkg::BYTE_W-1:0] data;
      lpfd_pkg::status_type        status;
      logic                        last;
   } byte_report_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [lpfd_pkg::BYTE_W-1:0]   req_tdata;   // [7:0] data_byte
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [lpfd_pkg::BYTE_W-1:0]   rsp_tdata;   // [7:0] echo_byte
   logic [lpfd_pkg::STATUS_W-1:0] rsp_tuser;   // [2:0] status
   logic                          rsp_tlast;
   logic                          csr_we;
   logic [lpfd_pkg::CSR_AW-1:0]   csr_addr;
   logic [lpfd_pkg::BYTE_W-1:0]   csr_wdata;

   // Register copies used by the predictor
   logic [lpfd_pkg::BYTE_W-1:0] prim_code;
   logic [lpfd_pkg::BYTE_W-1:0] alt_code;
   logic [lpfd_pkg::TAIL_W-1:0] tail_len;
   logic [lpfd_pkg::BYTE_W-1:0] min_len;
   logic [lpfd_pkg::BYTE_W-1:0] max_len;

   // Frame state of the predictor
   deframe_phase_type           phase_q;
   logic [lpfd_pkg::CNT_W-1:0]  bytes_due_q;
   logic                        alt_frame_q;

   byte_report_type   pending_reports[$];

   int          mismatches    = 0;
   int          bytes_sent    = 0;
   int          frames_closed = 0;
   int          bad_starts    = 0;
   int          bad_lengths   = 0;
   int          settings_used = 1;
   int          idle_cycles   = 0;
   int          burst_left    = 0;
   int          gap_max       = 0;
   int          hold_left     = 0;
   int          pattern_step  = 0;
   rx_mode_type rx_mode       = RX_ALWAYS;

   length_prefixed_frame_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Advance the frame state by one byte and return the report for it
   function automatic byte_report_type deframe_byte(input logic [lpfd_pkg::BYTE_W-1:0] b);
      byte_report_type r;
      r.data   = b;
      r.last   = 1'b0;
      r.status = lpfd_pkg::ST_BAD_START;
      case (phase_q)
         AWAIT_LENGTH: begin
            if (b < min_len || b > max_len) begin
               r.status    = lpfd_pkg::ST_BAD_LEN;
               phase_q     = HUNTING;
               bytes_due_q = '0;
            end else begin
               r.status    = lpfd_pkg::ST_LEN_OK;
               bytes_due_q = {1'b0, b} + (alt_frame_q ? {5'b0, tail_len} : 9'd0);
               if (bytes_due_q == '0) begin
                  r.last  = 1'b1;
                  phase_q = HUNTING;
               end else begin
                  phase_q = IN_BODY;
               end
            end
         end
         IN_BODY: begin
            r.status    = lpfd_pkg::ST_BODY;
            bytes_due_q = bytes_due_q - 1'b1;
            if (bytes_due_q == '0) begin
               r.last  = 1'b1;
               phase_q = HUNTING;
            end
         end
         default: begin
            if (b == prim_code || b == alt_code) begin
               r.status    = lpfd_pkg::ST_START_OK;
               alt_frame_q = (b == alt_code);
               bytes_due_q = '0;
               phase_q     = AWAIT_LENGTH;
            end else begin
               r.status = lpfd_pkg::ST_BAD_START;
               phase_q  = HUNTING;
            end
         end
      endcase
      return r;
   endfunction

   // Predict on every accepted byte, check every accepted result, watch for hangs
   always @(posedge clock) begin : scoreboard
      byte_report_type exp;
      if (!reset) begin
         if (req_tvalid && req_tready)
            pending_reports.push_back(deframe_byte(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: data %02h status %0d last %0b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               exp = pending_reports.pop_front();
               if (exp.last) frames_closed++;
               if (exp.status == lpfd_pkg::ST_BAD_START) bad_starts++;
               if (exp.status == lpfd_pkg::ST_BAD_LEN) bad_lengths++;
               if (rsp_tdata !== exp.data || rsp_tuser !== exp.status ||
                   rsp_tlast !== exp.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch at %0t: expected data %02h status %0d last %0b,",
                              $realtime, exp.data, exp.status, exp.last,
                              " got data %02h status %0d last %0b",
                              rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_reports.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Receiver: long hold-off on request, otherwise stall per mode
   always @(negedge clock) begin
      pattern_step = pattern_step + 1;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= ($urandom_range(0, 99) >= 30);
            default:   rsp_tready <= ((pattern_step % 11) < 7);
         endcase
      end
   end

   // Offer one byte, in bursts with random gaps, and hold it until accepted
   task automatic send_byte(input logic [lpfd_pkg::BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Stop offering and wait for every outstanding result
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [lpfd_pkg::CSR_AW-1:0] idx,
                            input logic [lpfd_pkg::BYTE_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         lpfd_pkg::REG_PRIMARY_START:   prim_code = value;
         lpfd_pkg::REG_ALTERNATE_START: alt_code  = value;
         lpfd_pkg::REG_ALTERNATE_TAIL:  tail_len  = value[lpfd_pkg::TAIL_W-1:0];
         lpfd_pkg::REG_MIN_LENGTH:      min_len   = value;
         lpfd_pkg::REG_MAX_LENGTH:      max_len   = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(input logic [lpfd_pkg::BYTE_W-1:0] p,
                                 input logic [lpfd_pkg::BYTE_W-1:0] a,
                                 input logic [lpfd_pkg::BYTE_W-1:0] t,
                                 input logic [lpfd_pkg::BYTE_W-1:0] lo,
                                 input logic [lpfd_pkg::BYTE_W-1:0] hi);
      wait_drained();
      write_reg(lpfd_pkg::REG_PRIMARY_START, p);
      write_reg(lpfd_pkg::REG_ALTERNATE_START, a);
      write_reg(lpfd_pkg::REG_ALTERNATE_TAIL, t);
      write_reg(lpfd_pkg::REG_MIN_LENGTH, lo);
      write_reg(lpfd_pkg::REG_MAX_LENGTH, hi);
      settings_used++;
   endtask

   // Send a start byte, a length byte and the body the frame calls for, stopping
   // after a bad start or bad length. Assumes the deframer is hunting when called.
   task automatic send_frame(input logic [lpfd_pkg::BYTE_W-1:0] start,
                             input logic [lpfd_pkg::BYTE_W-1:0] len);
      int due;
      send_byte(start);
      if (start != prim_code && start != alt_code) return;
      send_byte(len);
      if (len < min_len || len > max_len) return;
      due = int'(len) + ((start == alt_code) ? int'(tail_len) : 0);
      repeat (due) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Line noise that never matches a start code
   task automatic send_noise();
      logic [lpfd_pkg::BYTE_W-1:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == prim_code || b == alt_code);
      send_byte(b);
   endtask

   // Mostly well-formed frames with short bodies; some noise and bad headers
   task automatic run_random_traffic(input int n_bytes);
      int target;
      int pick;
      int span;
      logic [lpfd_pkg::BYTE_W-1:0] start;
      logic [lpfd_pkg::BYTE_W-1:0] len;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_noise();
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      start = prim_code;
            else if (pick < 90) start = alt_code;
            else                start = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (min_len <= max_len && pick < 82) begin
               span = int'(max_len) - int'(min_len);
               if (span > 12) span = 12;
               len = 8'(int'(min_len) + $urandom_range(0, span));
            end else if (min_len <= max_len && pick < 84) begin
               len = 8'($urandom_range(min_len, max_len));
            end else begin
               len = 8'($urandom_range(0, 255));
            end
            send_frame(start, len);
         end
      end
   endtask

   // Both start codes, bad start bytes and lengths just outside the window
   task automatic test_default_frames();
      gap_max = 3;
      rx_mode = RX_RANDOM;
      send_frame(prim_code, min_len);
      send_frame(alt_code, min_len);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(prim_code, min_len - 1'b1);
      send_frame(alt_code, max_len + 1'b1);
   endtask

   // Equal start codes, a frame whose length byte closes it, a one-byte body and a zero length with a tail
   task automatic test_zero_length_frames();
      apply_settings(8'h00, 8'h00, 8'hF0, 8'd0, 8'd255);
      send_frame(prim_code, 8'd0);
      send_frame(prim_code, 8'd1);
      wait_drained();
      write_reg(lpfd_pkg::REG_ALTERNATE_TAIL, 8'hFF);
      send_frame(alt_code, 8'd0);
   endtask

   // Minimum above maximum rejects every length
   task automatic test_inverted_length_window();
      apply_settings(8'h5A, 8'hA5, 8'h03, 8'd200, 8'd10);
      send_frame(prim_code, 8'd10);
      send_frame(alt_code, 8'd200);
      send_frame(prim_code, 8'd100);
   endtask

   // Writes to unused indexes must leave every register alone
   task automatic test_unused_register_index();
      int idx;
      wait_drained();
      for (idx = int'(lpfd_pkg::REG_MAX_LENGTH) + 1; idx < (1 << lpfd_pkg::CSR_AW); idx++)
         write_reg(3'(idx), 8'hFF);
      send_frame(prim_code, 8'd10);
      send_frame(alt_code, 8'd10);
   endtask

   // Hold the receiver off so the deframer fills and stalls its input
   task automatic test_backpressure();
      apply_settings(lpfd_pkg::RST_PRIMARY_START, lpfd_pkg::RST_ALTERNATE_START,
                     8'(lpfd_pkg::RST_ALTERNATE_TAIL),
                     lpfd_pkg::RST_MIN_LENGTH, lpfd_pkg::RST_MAX_LENGTH);
      gap_max   = 0;
      rx_mode   = RX_ALWAYS;
      hold_left = 150;
      run_random_traffic(60);
      wait_drained();
   endtask

   task automatic test_random_traffic();
      logic [lpfd_pkg::BYTE_W-1:0] lo;
      logic [lpfd_pkg::BYTE_W-1:0] code;

      gap_max = 4;
      rx_mode = RX_RANDOM;
      run_random_traffic(200);

      // window of 1 to 255, longest tail, one frame of the largest size
      apply_settings(8'hFF, 8'h00, 8'h0F, 8'd1, 8'd255);
      gap_max = 0;
      rx_mode = RX_ALWAYS;
      send_frame(alt_code, 8'hFF);
      run_random_traffic(200);

      // narrowest window, no tail
      apply_settings(8'h00, 8'hFF, 8'h00, 8'd1, 8'd1);
      gap_max = 8;
      rx_mode = RX_PATTERN;
      run_random_traffic(200);

      repeat (2) begin
         lo = 8'($urandom_range(1, 20));
         apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), lo,
                        8'(int'(lo) + $urandom_range(0, 40)));
         gap_max = $urandom_range(0, 6);
         rx_mode = ($urandom_range(0, 1) != 0) ? RX_RANDOM : RX_PATTERN;
         run_random_traffic(200);
      end

      // equal start codes
      code = 8'($urandom_range(0, 255));
      apply_settings(code, code, 8'($urandom_range(0, 255)), 8'd1, 8'd8);
      gap_max = 2;
      rx_mode = RX_RANDOM;
      run_random_traffic(200);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_we      = 1'b0;
      csr_addr    = '0;
      csr_wdata   = '0;
      prim_code   = lpfd_pkg::RST_PRIMARY_START;
      alt_code    = lpfd_pkg::RST_ALTERNATE_START;
      tail_len    = lpfd_pkg::RST_ALTERNATE_TAIL;
      min_len     = lpfd_pkg::RST_MIN_LENGTH;
      max_len     = lpfd_pkg::RST_MAX_LENGTH;
      phase_q     = HUNTING;
      bytes_due_q = '0;
      alt_frame_q = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_frames();
      test_zero_length_frames();
      test_inverted_length_window();
      test_unused_register_index();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      $display("covered %0d bytes under %0d register settings:",
               bytes_sent, settings_used);
      $display("  %0d frames closed, %0d bad starts, %0d bad lengths",
               frames_closed, bad_starts, bad_lengths);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0 && pending_reports.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ length_prefixed_frame_deframer_top.f @@
src/lpfd_pkg.sv
src/length_prefixed_frame_deframer_top.sv
verif/tb.sv
